### rtl/qvr_pkg.sv
// qvr_pkg: widths, bus type and constant tables of the quaternion rotation block
// used by qvr_cordic_cell and quaternion_vector_rotation; no dependencies
package qvr_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int COORD_WIDTH   = 16;

   // cordic datapath widths
   localparam int XW  = 33;
   localparam int ZW  = 33;
   localparam int IDW = 5;

   // quaternion datapath widths
   localparam int AXW = 16;
   localparam int QW  = 19;
   localparam int P1W = QW + COORD_WIDTH;
   localparam int S1W = P1W + 3;
   localparam int QPW = S1W - 10;
   localparam int P2W = QPW + QW;
   localparam int S2W = P2W + 3;
   localparam int RW  = S2W - 18;

   localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(652032874);
   localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(64'sd1073741824);

   typedef struct packed {
      logic                           valid;
      logic signed [COORD_WIDTH-1:0]  px;
      logic signed [COORD_WIDTH-1:0]  py;
      logic signed [COORD_WIDTH-1:0]  pz;
      logic signed [AXW-1:0]          ax;
      logic signed [AXW-1:0]          ay;
      logic signed [AXW-1:0]          az;
      logic signed [XW-1:0]           x;
      logic signed [XW-1:0]           y;
      logic signed [ZW-1:0]           z;
   } cordic_bus_type;

   // arctangent of 2^-i in phase units (2^32 = one turn)
   function automatic logic signed [ZW-1:0] atan_phase(input logic [IDW-1:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:    v = 32'h20000000;
         5'd1:    v = 32'h12E4051E;
         5'd2:    v = 32'h09FB385B;
         5'd3:    v = 32'h051111D4;
         5'd4:    v = 32'h028B0D43;
         5'd5:    v = 32'h0145D7E1;
         5'd6:    v = 32'h00A2F61E;
         5'd7:    v = 32'h00517C55;
         5'd8:    v = 32'h0028BE53;
         5'd9:    v = 32'h00145F2F;
         5'd10:   v = 32'h000A2F98;
         5'd11:   v = 32'h000517CC;
         5'd12:   v = 32'h00028BE6;
         5'd13:   v = 32'h000145F3;
         5'd14:   v = 32'h0000A2FA;
         5'd15:   v = 32'h0000517D;
         5'd16:   v = 32'h000028BE;
         5'd17:   v = 32'h0000145F;
         5'd18:   v = 32'h00000A30;
         5'd19:   v = 32'h00000518;
         5'd20:   v = 32'h0000028C;
         5'd21:   v = 32'h00000146;
         5'd22:   v = 32'h000000A3;
         5'd23:   v = 32'h00000051;
         default: v = 32'h00000000;
      endcase
      return $signed({1'b0, v});
   endfunction

   // clamp a rounded sine or cosine to +-1.0 in Q14
   function automatic logic signed [15:0] clamp_q14(input logic signed [18:0] v);
      logic signed [18:0] r;
      if (v > 19'sd16384) begin
         r = 19'sd16384;
      end else if (v < -19'sd16384) begin
         r = -19'sd16384;
      end else begin
         r = v;
      end
      return r[15:0];
   endfunction

endpackage

### rtl/qvr_cordic_cell.sv
// qvr_cordic_cell: one rotation-mode cordic micro-rotation with its pipeline register
// depends on qvr_pkg (bus type, arctangent table)
module qvr_cordic_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  logic [qvr_pkg::IDW-1:0] stage_idx,
   input  qvr_pkg::cordic_bus_type bus_in,
   output qvr_pkg::cordic_bus_type bus_out
);
   import qvr_pkg::*;

   cordic_bus_type bus_ff;
   cordic_bus_type bus_in_next;
   logic signed [XW-1:0] dx;
   logic signed [XW-1:0] dy;
   logic signed [ZW-1:0] ang;

   // micro-rotation in the direction of the remaining angle
   always_comb begin
      dx = bus_in.y >>> stage_idx;
      dy = bus_in.x >>> stage_idx;
      ang = atan_phase(stage_idx);
      bus_in_next = bus_in;
      if (!bus_in.z[ZW-1]) begin
         bus_in_next.x = bus_in.x - dx;
         bus_in_next.y = bus_in.y + dy;
         bus_in_next.z = bus_in.z - ang;
      end else begin
         bus_in_next.x = bus_in.x + dx;
         bus_in_next.y = bus_in.y - dy;
         bus_in_next.z = bus_in.z + ang;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_ff.valid <= 1'b0;
      end else if (enable) begin
         bus_ff <= bus_in_next;
      end
   end

   assign bus_out = bus_ff;

endmodule

### rtl/quaternion_vector_rotation.sv
// quaternion_vector_rotation: top level, cordic cell chain and sandwich-product pipeline
// depends on qvr_pkg and qvr_cordic_cell
//
// Rotates a Q4.12 point about a Q1.14 unit axis by a 16-bit binary angle, one
// transaction per cycle while the output is not stalled. The half-angle sine
// and cosine come from a chain of CORDIC_STAGES cordic cells, followed by six
// stages of quaternion arithmetic and the output register. The whole pipeline
// advances together: req_ready is high whenever the output register is empty
// or being taken. The axis is not normalised; the result is saturated and
// flagged.
module quaternion_vector_rotation (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [qvr_pkg::COORD_WIDTH-1:0]  req_point_x,
   input  logic signed [qvr_pkg::COORD_WIDTH-1:0]  req_point_y,
   input  logic signed [qvr_pkg::COORD_WIDTH-1:0]  req_point_z,
   input  logic [15:0]                             req_turn_angle,
   input  logic signed [15:0]                      req_axis_x,
   input  logic signed [15:0]                      req_axis_y,
   input  logic signed [15:0]                      req_axis_z,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [qvr_pkg::COORD_WIDTH-1:0]  rsp_rotated_x,
   output logic signed [qvr_pkg::COORD_WIDTH-1:0]  rsp_rotated_y,
   output logic signed [qvr_pkg::COORD_WIDTH-1:0]  rsp_rotated_z,
   output logic                                    rsp_saturated_flag
);
   import qvr_pkg::*;

   localparam logic signed [COORD_WIDTH-1:0] OUT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] OUT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
   localparam logic signed [RW-1:0] SAT_HI = RW'(OUT_MAX);
   localparam logic signed [RW-1:0] SAT_LO = RW'(OUT_MIN);
   localparam logic signed [XW:0]   RND16 = (XW+1)'(32768);
   localparam logic signed [32:0]   RND14 = 33'sd8192;
   localparam logic signed [S1W-1:0] RND10 = S1W'(512);
   localparam logic signed [S2W-1:0] RND18 = S2W'(131072);

   logic en;
   cordic_bus_type chain [CORDIC_STAGES+1];

   // pipeline valids after the cordic chain
   logic va_ff, vb_ff, vc_ff, vd_ff, ve_ff, vf_ff, out_vld_ff;

   // stage a: rounded cosine and sine of the half angle
   logic signed [15:0] c_ff, s_ff, c_in, s_in;
   logic signed [COORD_WIDTH-1:0] pa_ff [3];
   logic signed [AXW-1:0] aa_ff [3];

   // stage b: rotation quaternion
   logic signed [QW-1:0] qb_ff [4];
   logic signed [QW-1:0] qb_in [4];
   logic signed [COORD_WIDTH-1:0] pb_ff [3];

   // stage c: q * p partial products, stage d: q * p
   logic signed [P1W-1:0] m1_ff [12];
   logic signed [QW-1:0]  qc_ff [4];
   logic signed [QW-1:0]  qd_ff [4];
   logic signed [QPW-1:0] qp_ff [4];
   logic signed [QPW-1:0] qp_in [4];

   // stage e: (q * p) * conj(q) partial products, stage f: rotated vector
   logic signed [P2W-1:0] m2_ff [12];
   logic signed [RW-1:0]  r_ff [3];
   logic signed [RW-1:0]  r_in [3];

   // output register
   logic signed [COORD_WIDTH-1:0] o_ff [3];
   logic signed [COORD_WIDTH-1:0] o_in [3];
   logic sat_ff, sat_in;

   assign en = !out_vld_ff || rsp_ready;
   assign req_ready = en;

   // cordic chain input: phase of the half angle shifted by a quarter turn
   always_comb begin
      chain[0].valid = req_valid;
      chain[0].px = req_point_x;
      chain[0].py = req_point_y;
      chain[0].pz = req_point_z;
      chain[0].ax = req_axis_x;
      chain[0].ay = req_axis_y;
      chain[0].az = req_axis_z;
      chain[0].x = CORDIC_GAIN;
      chain[0].y = '0;
      chain[0].z = $signed({2'b00, req_turn_angle, 15'd0}) - QUARTER_TURN;
   end

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      qvr_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (en),
         .stage_idx (IDW'(g)),
         .bus_in    (chain[g]),
         .bus_out   (chain[g+1])
      );
   end

   // round and clamp; cos(h) = -sin(r), sin(h) = cos(r)
   always_comb begin
      logic signed [XW:0] ry;
      logic signed [XW:0] rx;
      ry = ($signed({chain[CORDIC_STAGES].y[XW-1], chain[CORDIC_STAGES].y}) + RND16) >>> 16;
      rx = ($signed({chain[CORDIC_STAGES].x[XW-1], chain[CORDIC_STAGES].x}) + RND16) >>> 16;
      c_in = clamp_q14(-ry[18:0]);
      s_in = clamp_q14(rx[18:0]);
   end

   // vector part of q as s * axis in Q14
   always_comb begin
      logic signed [32:0] t [3];
      t[0] = (33'(s_ff) * 33'(aa_ff[0]) + RND14) >>> 14;
      t[1] = (33'(s_ff) * 33'(aa_ff[1]) + RND14) >>> 14;
      t[2] = (33'(s_ff) * 33'(aa_ff[2]) + RND14) >>> 14;
      qb_in[0] = QW'(c_ff);
      qb_in[1] = t[0][QW-1:0];
      qb_in[2] = t[1][QW-1:0];
      qb_in[3] = t[2][QW-1:0];
   end

   // q * p sums; products indexed by q part (w,x,y,z) times point part (x,y,z)
   always_comb begin
      logic signed [S1W-1:0] sw, sx, sy, sz;
      sw = -(S1W'(m1_ff[3]) + S1W'(m1_ff[7]) + S1W'(m1_ff[11]));
      sx = S1W'(m1_ff[0]) + S1W'(m1_ff[8]) - S1W'(m1_ff[10]);
      sy = S1W'(m1_ff[1]) - S1W'(m1_ff[5]) + S1W'(m1_ff[9]);
      sz = S1W'(m1_ff[2]) + S1W'(m1_ff[4]) - S1W'(m1_ff[6]);
      sw = (sw + RND10) >>> 10;
      sx = (sx + RND10) >>> 10;
      sy = (sy + RND10) >>> 10;
      sz = (sz + RND10) >>> 10;
      qp_in[0] = sw[QPW-1:0];
      qp_in[1] = sx[QPW-1:0];
      qp_in[2] = sy[QPW-1:0];
      qp_in[3] = sz[QPW-1:0];
   end

   // sandwich sums for the vector part
   always_comb begin
      logic signed [S2W-1:0] sx, sy, sz;
      sx = -S2W'(m2_ff[0]) + S2W'(m2_ff[3]) - S2W'(m2_ff[8]) + S2W'(m2_ff[11]);
      sy = -S2W'(m2_ff[1]) + S2W'(m2_ff[5]) + S2W'(m2_ff[6]) - S2W'(m2_ff[10]);
      sz = -S2W'(m2_ff[2]) - S2W'(m2_ff[4]) + S2W'(m2_ff[7]) + S2W'(m2_ff[9]);
      sx = (sx + RND18) >>> 18;
      sy = (sy + RND18) >>> 18;
      sz = (sz + RND18) >>> 18;
      r_in[0] = sx[RW-1:0];
      r_in[1] = sy[RW-1:0];
      r_in[2] = sz[RW-1:0];
   end

   // output saturation
   always_comb begin
      sat_in = 1'b0;
      for (int k = 0; k < 3; k++) begin
         if (r_ff[k] > SAT_HI) begin
            o_in[k] = OUT_MAX;
            sat_in = 1'b1;
         end else if (r_ff[k] < SAT_LO) begin
            o_in[k] = OUT_MIN;
            sat_in = 1'b1;
         end else begin
            o_in[k] = r_ff[k][COORD_WIDTH-1:0];
         end
      end
   end

   // valid pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
         vf_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         va_ff <= chain[CORDIC_STAGES].valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
         ve_ff <= vd_ff;
         vf_ff <= ve_ff;
         out_vld_ff <= vf_ff;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (en) begin
         c_ff <= c_in;
         s_ff <= s_in;
         pa_ff[0] <= chain[CORDIC_STAGES].px;
         pa_ff[1] <= chain[CORDIC_STAGES].py;
         pa_ff[2] <= chain[CORDIC_STAGES].pz;
         aa_ff[0] <= chain[CORDIC_STAGES].ax;
         aa_ff[1] <= chain[CORDIC_STAGES].ay;
         aa_ff[2] <= chain[CORDIC_STAGES].az;
         qb_ff <= qb_in;
         pb_ff <= pa_ff;
         for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 3; j++) begin
               m1_ff[i*3+j] <= P1W'(qb_ff[i]) * P1W'(pb_ff[j]);
            end
         end
         qc_ff <= qb_ff;
         qd_ff <= qc_ff;
         qp_ff <= qp_in;
         m2_ff[0]  <= P2W'(qp_ff[0]) * P2W'(qd_ff[1]);
         m2_ff[1]  <= P2W'(qp_ff[0]) * P2W'(qd_ff[2]);
         m2_ff[2]  <= P2W'(qp_ff[0]) * P2W'(qd_ff[3]);
         m2_ff[3]  <= P2W'(qp_ff[1]) * P2W'(qd_ff[0]);
         m2_ff[4]  <= P2W'(qp_ff[1]) * P2W'(qd_ff[2]);
         m2_ff[5]  <= P2W'(qp_ff[1]) * P2W'(qd_ff[3]);
         m2_ff[6]  <= P2W'(qp_ff[2]) * P2W'(qd_ff[0]);
         m2_ff[7]  <= P2W'(qp_ff[2]) * P2W'(qd_ff[1]);
         m2_ff[8]  <= P2W'(qp_ff[2]) * P2W'(qd_ff[3]);
         m2_ff[9]  <= P2W'(qp_ff[3]) * P2W'(qd_ff[0]);
         m2_ff[10] <= P2W'(qp_ff[3]) * P2W'(qd_ff[1]);
         m2_ff[11] <= P2W'(qp_ff[3]) * P2W'(qd_ff[2]);
         r_ff <= r_in;
         o_ff <= o_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_rotated_x = o_ff[0];
   assign rsp_rotated_y = o_ff[1];
   assign rsp_rotated_z = o_ff[2];
   assign rsp_saturated_flag = sat_ff;

`ifndef SYNTHESIS
   // nothing leaves the block in the cycle after reset
   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

   // a flagged result has at least one component at a rail
   a_flag_at_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated_flag |->
         (rsp_rotated_x == OUT_MAX) || (rsp_rotated_x == OUT_MIN) ||
         (rsp_rotated_y == OUT_MAX) || (rsp_rotated_y == OUT_MIN) ||
         (rsp_rotated_z == OUT_MAX) || (rsp_rotated_z == OUT_MIN))
      else $error("saturation flag without a clipped component");

   // a stalled output freezes the pipeline
   a_stall_holds_tail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(vf_ff) && $stable(r_ff[0]))
      else $error("pipeline moved during output stall");
`endif

endmodule

### tb/sv/rotation_checker.sv
// rotation_checker: watches both channels of quaternion_vector_rotation, predicts each result
// and compares it with what the block returns; depends on qvr_pkg for the coordinate width
module rotation_checker (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   input  logic                                    req_ready,
   input  logic signed [qvr_pkg::COORD_WIDTH-1:0]  req_point_x,
   input  logic signed [qvr_pkg::COORD_WIDTH-1:0]  req_point_y,
   input  logic signed [qvr_pkg::COORD_WIDTH-1:0]  req_point_z,
   input  logic [15:0]                             req_turn_angle,
   input  logic signed [15:0]                      req_axis_x,
   input  logic signed [15:0]                      req_axis_y,
   input  logic signed [15:0]                      req_axis_z,
   input  logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   input  logic signed [qvr_pkg::COORD_WIDTH-1:0]  rsp_rotated_x,
   input  logic signed [qvr_pkg::COORD_WIDTH-1:0]  rsp_rotated_y,
   input  logic signed [qvr_pkg::COORD_WIDTH-1:0]  rsp_rotated_z,
   input  logic                                    rsp_saturated_flag,
   output int                                      mismatches,
   output int                                      pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW = qvr_pkg::COORD_WIDTH;

   typedef struct {
      logic signed [CW-1:0] rx;
      logic signed [CW-1:0] ry;
      logic signed [CW-1:0] rz;
      logic                 sat;
   } rotated_point_type;

   typedef struct {
      longint w;
      longint x;
      longint y;
      longint z;
   } quat_type;

   rotated_point_type rotated_queue[$];

   // arctangent of 2^-i, phase units with 2^32 per turn
   longint arctan_steps[24] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
      64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
      64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};

   // add half an lsb, then floor
   function automatic longint round_down(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clip_unit(longint v);
      return v > 16384 ? 16384 : (v < -16384 ? -16384 : v);
   endfunction

   function automatic quat_type hamilton_product(quat_type a, quat_type b, int s);
      quat_type r;
      r.w = round_down(a.w * b.w - a.x * b.x - a.y * b.y - a.z * b.z, s);
      r.x = round_down(a.w * b.x + a.x * b.w + a.y * b.z - a.z * b.y, s);
      r.y = round_down(a.w * b.y - a.x * b.z + a.y * b.w + a.z * b.x, s);
      r.z = round_down(a.w * b.z + a.x * b.y - a.y * b.x + a.z * b.w, s);
      return r;
   endfunction

   function automatic longint clip_coord(longint v, ref logic sat);
      longint hi;
      hi = (64'sd1 <<< (CW - 1)) - 1;
      if (v > hi) begin
         sat = 1'b1;
         return hi;
      end
      if (v < -hi - 1) begin
         sat = 1'b1;
         return -hi - 1;
      end
      return v;
   endfunction

   function automatic rotated_point_type rotate_point(longint px, longint py, longint pz,
                                                       longint ang, longint ax, longint ay,
                                                       longint az);
      longint cx, cy, cz, dx, dy, cosv, sinv;
      quat_type q, qc, p, qp, r;
      rotated_point_type o;
      logic sat;
      // cordic on the half angle shifted back by a quarter turn
      cx = 64'sd652032874;
      cy = 0;
      cz = (ang <<< 15) - (64'sd1 <<< 30);
      for (int i = 0; i < qvr_pkg::CORDIC_STAGES && i < 24; i++) begin
         dx = cy >>> i;
         dy = cx >>> i;
         if (cz >= 0) begin
            cx -= dx; cy += dy; cz -= arctan_steps[i];
         end else begin
            cx += dx; cy -= dy; cz += arctan_steps[i];
         end
      end
      cosv = clip_unit(-round_down(cy, 16));
      sinv = clip_unit(round_down(cx, 16));
      q = '{cosv, round_down(sinv * ax, 14), round_down(sinv * ay, 14),
            round_down(sinv * az, 14)};
      qc = '{q.w, -q.x, -q.y, -q.z};
      p = '{0, px, py, pz};
      qp = hamilton_product(q, p, 10);
      r = hamilton_product(qp, qc, 18);
      sat = 1'b0;
      o.rx = CW'(clip_coord(r.x, sat));
      o.ry = CW'(clip_coord(r.y, sat));
      o.rz = CW'(clip_coord(r.z, sat));
      o.sat = sat;
      return o;
   endfunction

   assign pending = rotated_queue.size();

   // predict on accepted requests, compare on accepted responses
   always @(posedge clock) begin
      rotated_point_type exp_pt;
      if (reset) begin
         mismatches <= 0;
      end else begin
         if (req_valid && req_ready) begin
            rotated_queue.push_back(rotate_point(req_point_x, req_point_y, req_point_z,
                                                 {48'd0, req_turn_angle}, req_axis_x,
                                                 req_axis_y, req_axis_z));
         end
         if (rsp_valid && rsp_ready) begin
            if (rotated_queue.size() == 0) begin
               $display("%0t: unexpected transaction x=%0d y=%0d z=%0d sat=%0b", $time,
                        rsp_rotated_x, rsp_rotated_y, rsp_rotated_z, rsp_saturated_flag);
               mismatches <= mismatches + 1;
            end else begin
               exp_pt = rotated_queue.pop_front();
               if (exp_pt.rx !== rsp_rotated_x || exp_pt.ry !== rsp_rotated_y ||
                   exp_pt.rz !== rsp_rotated_z || exp_pt.sat !== rsp_saturated_flag) begin
                  $display({"%0t: mismatch expected x=%0d y=%0d z=%0d sat=%0b",
                            " got x=%0d y=%0d z=%0d sat=%0b"},
                           $time, exp_pt.rx, exp_pt.ry, exp_pt.rz, exp_pt.sat,
                           rsp_rotated_x, rsp_rotated_y, rsp_rotated_z, rsp_saturated_flag);
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
   end

endmodule

### tb/sv/tb.sv
// tb: stimulus and verdict for quaternion_vector_rotation
// depends on qvr_pkg, the block and rotation_checker
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW = qvr_pkg::COORD_WIDTH;
   localparam int LATENCY = qvr_pkg::CORDIC_STAGES + 7;
   localparam int RANDOM_POINTS = 630;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [CW-1:0] req_point_x = '0, req_point_y = '0, req_point_z = '0;
   logic [15:0] req_turn_angle = '0;
   logic signed [15:0] req_axis_x = '0, req_axis_y = '0, req_axis_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [CW-1:0] rsp_rotated_x, rsp_rotated_y, rsp_rotated_z;
   logic rsp_saturated_flag;
   int mismatches, pending;
   int stall_left = 0;
   bit calm_tail = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   quaternion_vector_rotation u_top (.*);
   rotation_checker u_check (.*);

   // send one point, optionally after a short idle burst
   task automatic send_point(input logic [CW-1:0] px, py, pz, input logic [15:0] ang,
                             input logic [15:0] ax, ay, az);
      if (!calm_tail && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_point_x <= px; req_point_y <= py; req_point_z <= pz;
      req_turn_angle <= ang;
      req_axis_x <= ax; req_axis_y <= ay; req_axis_z <= az;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'($urandom_range(0, 1023)) - 16'd512;
         default: return 16'($urandom);
      endcase
   endfunction

   // receiver stalls in random bursts; it stays ready in the calm tail
   always @(posedge clock) begin
      if (calm_tail || reset) begin
         rsp_ready <= !reset;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= (stall_left == 1);
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_ready <= 1'b0;
         stall_left <= int'($urandom_range(1, 3));
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      logic [15:0] unit_axes[6];
      logic [15:0] ax, ay, az;
      int k;
      unit_axes = '{16'sd16384, -16'sd16384, 16'sd0, 16'sd11585, -16'sd11585, 16'sd9459};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: extreme points and angles about each axis
      send_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 16'sd16384, 0, 0);
      send_point(16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, 16'sd16384, 0);
      send_point(16'h7FFF, 16'h8000, 16'h0001, 16'h4000, 0, 0, 16'sd16384);
      send_point(16'h1000, 16'h0000, 16'h0000, 16'hC000, 0, 0, 16'sd16384);
      send_point(16'h1000, 16'h2000, 16'h3000, 16'hFFFF, -16'sd16384, 0, 0);
      send_point(16'h7FFF, 16'h7FFF, 16'h0000, 16'h2000, 0, 0, 16'sd16384);
      send_point(16'h8000, 16'h7FFF, 16'h8000, 16'h6000, 16'sd9459, 16'sd9459, 16'sd9459);
      send_point(16'h0000, 16'h0000, 16'h0000, 16'h1234, 16'sd16384, 16'sd16384, 0);
      // non-unit and out-of-range axes
      send_point(16'h7000, 16'h7000, 16'h7000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_point(16'h4000, 16'hC000, 16'h2000, 16'h4000, 16'h8000, 16'h8000, 16'h8000);
      send_point(16'h0800, 16'h0800, 16'h0800, 16'h0001, 16'hFFFF, 16'h5555, 16'hAAAA);
      send_point(16'h0100, 16'h0200, 16'h0300, 16'h8001, 0, 0, 0);
      // sender holds off until the pipeline drains
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      // random points, axis components mostly drawn from the unit_axes table
      for (k = 0; k < RANDOM_POINTS; k++) begin
         if (k == RANDOM_POINTS - 80) calm_tail = 1'b1;
         if ($urandom_range(0, 3) != 0) begin
            ax = unit_axes[$urandom_range(0, 5)];
            ay = unit_axes[$urandom_range(0, 5)];
            az = unit_axes[$urandom_range(0, 5)];
         end else begin
            ax = 16'($urandom); ay = 16'($urandom); az = 16'($urandom);
         end
         send_point(rand_coord(), rand_coord(), rand_coord(), 16'($urandom), ax, ay, az);
      end
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
